[rtl/core/wfqm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfqm_pkg
// Shared constants, codes and types of the weighted fair queue marker.
// ----------------------------------------------------------------------------
package wfqm_pkg;

  localparam int unsigned Queues       = 8;
  localparam int unsigned PktsPerQueue = 64;
  localparam int unsigned SizeBits     = 14;

  localparam int unsigned QW   = $clog2(Queues);
  localparam int unsigned PW   = $clog2(PktsPerQueue);
  localparam int unsigned CW   = PW + 1;
  localparam int unsigned AW   = QW + PW;
  localparam int unsigned Depth = Queues * PktsPerQueue;
  localparam int unsigned FtW  = 48;

  localparam logic [FtW-1:0] FtMax = '1;

  // actions
  localparam logic [1:0] ActEnq  = 2'd0;
  localparam logic [1:0] ActDeq  = 2'd1;
  localparam logic [1:0] ActTick = 2'd2;

  // marking modes
  localparam logic [1:0] ModeQueue = 2'd0;
  localparam logic [1:0] ModePort  = 2'd1;
  localparam logic [1:0] ModeShare = 2'd2;

  // register indexes
  localparam logic [2:0] RegMode   = 3'd0;
  localparam logic [2:0] RegWeight = 3'd1;
  localparam logic [2:0] RegThresh = 3'd2;
  localparam logic [2:0] RegPort   = 3'd3;
  localparam logic [2:0] RegMean   = 3'd4;
  localparam logic [2:0] RegBuffer = 3'd5;
  localparam logic [2:0] RegAlpha  = 3'd6;
  localparam logic [2:0] RegQueues = 3'd7;

  // request to the divider
  typedef struct packed {
    logic        start;
    logic [21:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [21:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/weighted_fair_queue_ecn_marker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_fair_queue_ecn_marker_core
// Weighted fair queuing scheduler for one port with ECN marking.
// ----------------------------------------------------------------------------
// One item at a time: an item is taken only while the block is idle and its
// previous result has been handed over, and the next one can be taken the
// cycle after that handover. Packet sizes live in a 512 x 14 single-port RAM
// (one read or write per cycle, registered read). A drop, an unknown action
// and a tick need neither the divider nor the scan. Every dequeue scans the
// head finish times of the n queues in use, one queue per cycle. An enqueue
// to an empty queue and a dequeue that leaves packets behind also run the
// bit-serial finish-time divider (22 steps), and an enqueue in weighted-share
// mode takes a second multiply when it is needed. The result sits in an
// output register until it is taken.
module weighted_fair_queue_ecn_marker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  queue_id_i,
  input  logic [13:0] pkt_size_i,
  input  logic        ect_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        dropped_o,
  output logic        ce_mark_o,
  output logic        served_valid_o,
  output logic [2:0]  served_queue_o,
  output logic [13:0] served_size_o
);
  import wfqm_pkg::*;

  // states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDec   = 4'd1;
  localparam logic [3:0] StDiv   = 4'd2;
  localparam logic [3:0] StMark  = 4'd3;
  localparam logic [3:0] StScan  = 4'd4;
  localparam logic [3:0] StRdH   = 4'd5;
  localparam logic [3:0] StRdN   = 4'd6;
  localparam logic [3:0] StNxt   = 4'd7;
  localparam logic [3:0] StTick  = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;
  localparam logic [3:0] StMul   = 4'd10;
  localparam logic [3:0] StRdW   = 4'd11;
  localparam logic [3:0] StTick2 = 4'd12;

  // configuration registers
  logic [1:0]  mode_q;
  logic [63:0] weights_q, thresh_q;
  logic [7:0]  port_q;
  logic [13:0] mean_q;
  logic [23:0] buf_q;
  logic [15:0] alpha_q;
  logic [3:0]  nq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeQueue;
      weights_q <= 64'h0101010101010101;
      thresh_q  <= '0;
      port_q    <= 8'd65;
      mean_q    <= 14'd1500;
      buf_q     <= 24'd96000;
      alpha_q   <= '0;
      nq_q      <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegMode:   mode_q    <= cfg_data_i[1:0];
        RegWeight: weights_q <= cfg_data_i;
        RegThresh: thresh_q  <= cfg_data_i;
        RegPort:   port_q    <= cfg_data_i[7:0];
        RegMean:   mean_q    <= cfg_data_i[13:0];
        RegBuffer: buf_q     <= cfg_data_i[23:0];
        RegAlpha:  alpha_q   <= cfg_data_i[15:0];
        RegQueues: nq_q      <= cfg_data_i[3:0];
        default:   ;
      endcase
    end
  end

  // per-queue state
  logic [23:0]    qbytes_q [Queues];
  logic [CW-1:0]  qpkts_q  [Queues];
  logic [PW-1:0]  rhead_q  [Queues];
  logic [FtW-1:0] hfin_q   [Queues];
  logic [FtW-1:0] vt_q;
  logic [10:0]    aws_q;
  logic [26:0]    sws_q;
  logic [23:0]    tot_q;

  // item and control
  logic [3:0]  st_q;
  logic [1:0]  act_q;
  logic [QW-1:0] q_q;
  logic [13:0] size_q;
  logic        ect_q;
  logic [QW:0] scan_q;
  logic        found_q;
  logic [QW-1:0] best_q;
  logic [2:0]  step_q;
  logic [63:0] pa_q, pb_q;
  logic        drop_r, mark_r, sv_r;
  logic [2:0]  sq_r;
  logic [13:0] ss_r;
  logic        ov_q;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [13:0]   ram_rd;

  wfqm_ram #(.Width(14), .Depth(Depth)) u_sizes (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (size_q),
    .rdata_o (ram_rd)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  wfqm_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // helpers
  logic [3:0] nused;
  always_comb begin
    nused = (nq_q > 4'd8) ? 4'd8 : nq_q;
    if (nused == 4'd0) nused = 4'd1;
  end

  function automatic logic [7:0] wgt(input logic [63:0] w, input logic [2:0] q);
    logic [7:0] v;
    v = w[{q, 3'b000} +: 8];
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  logic [7:0]  wq;
  logic [2:0]  q3;
  logic [7:0]  qid_mapped;
  logic [PW-1:0] tail_slot;
  logic [FtW:0]  ft_sum;
  logic [FtW-1:0] ft_sat;
  logic [FtW-1:0] base_ft;

  assign q3 = 3'(q_q);
  assign wq = wgt(weights_q, q3);
  assign qid_mapped = (queue_id_i >= {4'd0, nused}) ? {4'd0, nused - 4'd1} : queue_id_i;
  assign tail_slot = rhead_q[q_q] + qpkts_q[q_q][PW-1:0];
  assign base_ft = (act_q == ActEnq) ? vt_q : hfin_q[q_q];
  assign ft_sum  = {1'b0, base_ft} + {{(FtW-22+1){1'b0}}, drsp.quotient};
  assign ft_sat  = ft_sum[FtW] ? FtMax : ft_sum[FtW-1:0];

  assign in_ready_o  = (st_q == StIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign dropped_o      = drop_r;
  assign ce_mark_o      = mark_r;
  assign served_valid_o = sv_r;
  assign served_queue_o = sq_r;
  assign served_size_o  = ss_r;

  // ram addressing
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = {q_q, tail_slot};
    if (st_q == StDec && act_q == ActEnq) ram_we = 1'b0;
    if (st_q == StRdW) ram_we = 1'b1;
    if (st_q == StRdH) ram_addr = {best_q, rhead_q[best_q]};
    if (st_q == StRdN) ram_addr = {best_q, rhead_q[best_q]};
    if (st_q == StMul) ram_addr = {best_q, rhead_q[best_q]};
  end

  // divider start
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = wq;
    if (st_q == StRdW) begin
      dreq.dividend = {size_q, 8'd0};
    end else if (st_q == StNxt) begin
      dreq.dividend = {ram_rd, 8'd0};
    end
    if (st_q == StRdW && qpkts_q[q_q] == '0) dreq.start = 1'b1;
    if (st_q == StNxt) dreq.start = 1'b1;
  end

  logic bigger_share;
  assign bigger_share = (sws_q == '0) || ({3'd0, wq, 16'd0} >= sws_q);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      ov_q  <= 1'b0;
      vt_q  <= '0;
      aws_q <= '0;
      sws_q <= '0;
      tot_q <= '0;
      for (int i = 0; i < Queues; i++) begin
        qbytes_q[i] <= '0;
        qpkts_q[i]  <= '0;
        rhead_q[i]  <= '0;
        hfin_q[i]   <= FtMax;
      end
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            act_q  <= action_i;
            q_q    <= qid_mapped[QW-1:0];
            size_q <= pkt_size_i;
            ect_q  <= ect_i;
            drop_r <= 1'b0; mark_r <= 1'b0; sv_r <= 1'b0;
            sq_r   <= '0;   ss_r   <= '0;
            scan_q <= '0; found_q <= 1'b0; best_q <= '0;
            st_q   <= StDec;
          end
        end
        StDec: begin
          priority if (act_q == ActEnq) begin
            if ({1'b0, tot_q} + {11'd0, size_q} > {1'b0, buf_q}
                || qpkts_q[q_q] >= CW'(PktsPerQueue)) begin
              drop_r <= 1'b1;
              st_q   <= StOut;
            end else begin
              st_q <= StRdW;
            end
          end else if (act_q == ActDeq) begin
            st_q <= StScan;
          end else if (act_q == ActTick) begin
            pa_q <= {37'd0, sws_q} * {48'd0, alpha_q};
            pb_q <= {37'd0, aws_q, 16'd0} * {47'd0, 17'h10000 - {1'b0, alpha_q}};
            st_q <= StTick;
          end else begin
            st_q <= StOut;
          end
        end
        StRdW: begin
          // store the size, account, then finish time if first packet
          if (qpkts_q[q_q] == '0) begin
            aws_q <= ({1'b0, aws_q} + {4'd0, wq} > 12'd2047) ? 11'd2047
                     : aws_q + {3'd0, wq};
          end
          qpkts_q[q_q]  <= qpkts_q[q_q] + 1'b1;
          qbytes_q[q_q] <= qbytes_q[q_q] + {10'd0, size_q};
          tot_q         <= tot_q + {10'd0, size_q};
          st_q <= (qpkts_q[q_q] == '0) ? StDiv : StMark;
          step_q <= '0;
        end
        StDiv: begin
          if (drsp.done) begin
            if (act_q == ActEnq) begin
              hfin_q[q_q] <= ft_sat;
              vt_q        <= ft_sat;
              st_q        <= StMark;
            end else begin
              hfin_q[q_q] <= ft_sat;
              if (vt_q < ft_sat) vt_q <= ft_sat;
              st_q <= StOut;
            end
          end
        end
        StMark: begin
          // step 0: products; step 1: compare, or a second multiply in share mode; step 2: compare
          if (step_q == 3'd0) begin
            unique case (mode_q)
              ModeQueue: begin
                pa_q <= {40'd0, qbytes_q[q_q]};
                pb_q <= {42'd0, thresh_q[{q3, 3'b000} +: 8]} * {50'd0, mean_q};
              end
              ModePort: begin
                pa_q <= {40'd0, tot_q};
                pb_q <= {56'd0, port_q} * {50'd0, mean_q};
              end
              default: begin
                pa_q <= {40'd0, qbytes_q[q_q]};
                pb_q <= {56'd0, port_q} * {50'd0, mean_q};
              end
            endcase
            step_q <= 3'd1;
          end else if (step_q == 3'd1) begin
            if (mode_q == ModeShare && !bigger_share) begin
              pa_q   <= {40'd0, pa_q[23:0]} * {37'd0, sws_q};
              pb_q   <= {42'd0, pb_q[21:0]} * {40'd0, wq, 16'd0};
              step_q <= 3'd2;
            end else begin
              mark_r <= ect_q && (mode_q != 2'd3) && (pa_q > pb_q);
              st_q   <= StOut;
            end
          end else begin
            mark_r <= ect_q && (pa_q > pb_q);
            st_q   <= StOut;
          end
        end
        StScan: begin
          // one queue per cycle
          if (scan_q == (QW+1)'(nused)) begin
            if (found_q) st_q <= StRdH;
            else st_q <= StOut;
          end else begin
            if (qpkts_q[scan_q[QW-1:0]] != '0 &&
                (!found_q || hfin_q[scan_q[QW-1:0]] < hfin_q[best_q])) begin
              best_q  <= scan_q[QW-1:0];
              found_q <= 1'b1;
            end
            scan_q <= scan_q + 1'b1;
          end
        end
        StRdH: begin
          q_q  <= best_q;
          st_q <= StRdN;
        end
        StRdN: begin
          // head data arrives now
          sv_r <= 1'b1;
          sq_r <= 3'(best_q);
          ss_r <= ram_rd;
          rhead_q[best_q]  <= rhead_q[best_q] + 1'b1;
          qpkts_q[best_q]  <= qpkts_q[best_q] - 1'b1;
          qbytes_q[best_q] <= qbytes_q[best_q] - {10'd0, ram_rd};
          tot_q            <= tot_q - {10'd0, ram_rd};
          if (qpkts_q[best_q] == CW'(1)) begin
            aws_q <= (aws_q > {3'd0, wq}) ? aws_q - {3'd0, wq} : '0;
            hfin_q[best_q] <= FtMax;
            st_q <= StOut;
          end else begin
            st_q <= StMul;
          end
        end
        StMul: begin
          // ram now addresses the new head
          st_q <= StNxt;
        end
        StNxt: begin
          st_q <= StDiv;
        end
        StTick: begin
          st_q <= StTick2;
        end
        StTick2: begin
          sws_q <= 27'((pa_q + pb_q) >> 16);
          st_q  <= StOut;
        end
        StOut: begin
          ov_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // total bytes never exceed the buffer limit it was checked against
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRdW) |=> tot_q <= buf_q)
    else $error("buffer overrun");
  // a drop never carries a mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(dropped_o && ce_mark_o))
    else $error("dropped item marked");
  // a served item is never a drop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && served_valid_o) |-> !dropped_o)
    else $error("served and dropped together");
  // queue 0, when empty and idle, holds the all-ones finish time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle && qpkts_q[0] == '0) |-> hfin_q[0] == FtMax)
    else $error("idle queue with finish time");

endmodule

[rtl/core/wfqm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfqm_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module wfqm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/core/wfqm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfqm_div
// Restoring divider, 22-bit dividend by 8-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module wfqm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wfqm_pkg::div_req_t  req_i,
  output wfqm_pkg::div_rsp_t  rsp_o
);
  import wfqm_pkg::*;

  logic [21:0] quo_q, quo_d;
  logic [8:0]  rem_q, rem_d;
  logic [7:0]  dsr_q, dsr_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [8:0]  trial;

  // shift in one dividend bit and try a subtract
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[7:0], quo_q[21]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = (req_i.divisor == 8'd0) ? 8'd1 : req_i.divisor;
      cnt_d  = 5'd22;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quo_d = {quo_q[20:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[20:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  // the remainder always stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < {1'b0, dsr_q})
    else $error("divider remainder out of range");
  // done pulses in the cycle after the last step, never while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 5'd1 && !req_i.start) |=> done_q)
    else $error("divider missed done");

endmodule
